// ----- hdl/ffba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and codes shared by the first-fit block allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 9;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 10;
    localparam int SIZE_W   = 15;
    localparam int HDR_BYTES = 2;

    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ACCESS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_POS  = 2'd1;
    localparam logic [1:0] RD_NXT  = 2'd2;
    localparam logic [1:0] RD_HND  = 2'd3;

    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_MERGE = 3'd1;
    localparam logic [2:0] WR_SPLIT = 3'd2;
    localparam logic [2:0] WR_BUSY  = 3'd3;
    localparam logic [2:0] WR_CLEAR = 3'd4;

    localparam logic [1:0] ADDR_ZERO = 2'd0;
    localparam logic [1:0] ADDR_POS  = 2'd1;
    localparam logic [1:0] ADDR_ACC  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FIELD_W-1:0]  request_size;
        logic [FIELD_W-1:0]  handle;
        logic [FIELD_W-1:0]  access_offset;
    } ffba_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   address;
    } ffba_rsp_t;

    typedef struct packed {
        logic                load;
        logic                init_step;
        logic [1:0]          rd_sel;
        logic                eval_hdr;
        logic                pos_adv;
        logic [2:0]          wr_sel;
        logic                wr_hi;
        logic                finish;
        logic [STATUS_W-1:0] fin_status;
        logic [1:0]          fin_addr;
    } ffba_cmd_t;

    typedef struct packed {
        logic                init_last;
        logic [ACTION_W-1:0] action;
        logic                too_big;
        logic                handle_low;
        logic                step_over;
        logic                hdr_busy;
        logic                hdr_small;
        logic                nxt_out;
        logic                can_split;
        logic                merge_ok;
        logic                hbyte_busy;
    } ffba_sts_t;

endpackage
`default_nettype wire

// ----- hdl/ffba_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_dpath
// Byte store, header read/write ports, walk registers and result register.
// ----------------------------------------------------------------------------
module ffba_dpath #(
    parameter int STORE_BYTES     = 512,
    parameter int MAX_BLOCK_BYTES = 255
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ffba_pkg::ffba_cmd_t  cmd,
    input  wire ffba_pkg::ffba_req_t  request,
    output ffba_pkg::ffba_sts_t       sts,
    output ffba_pkg::ffba_rsp_t       result
);
    import ffba_pkg::*;

    localparam int AW         = $clog2(STORE_BYTES);
    localparam int IW         = AW + 1;
    localparam int XW         = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
    localparam int STEP_LIMIT = 2 * STORE_BYTES + 4;
    localparam int SW         = $clog2(STEP_LIMIT + 1);
    localparam int PAY        = MAX_BLOCK_BYTES / 2;
    localparam int STRIDE     = PAY + HDR_BYTES;
    localparam int COUNT      = STORE_BYTES / STRIDE;
    localparam int REM        = STORE_BYTES % STRIDE;
    localparam int LAST_BASE  = COUNT * STRIDE;
    localparam int LAST_PAY   = PAY + ((REM == 1) ? 1 : 0);
    localparam int TAIL_SZ    = (REM >= HDR_BYTES) ? (REM - HDR_BYTES) : 0;
    localparam int PHW        = $clog2(STRIDE);

    logic [7:0]          mem [STORE_BYTES];

    ffba_req_t           req_reg, req_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [SW-1:0]       steps_reg, steps_next;
    logic                cur_busy_reg, cur_busy_next;
    logic [SIZE_W-1:0]   cur_sz_reg, cur_sz_next;
    logic [XW-1:0]       nxt_reg, nxt_next;
    logic [7:0]          rd_lo_reg, rd_hi_reg;
    logic [IW-1:0]       init_addr_reg, init_addr_next;
    logic [PHW-1:0]      phase_reg, phase_next;
    ffba_rsp_t           rsp_reg, rsp_next;

    logic [SIZE_W-1:0]   size15;
    logic [15:0]         hdr;
    logic [SIZE_W-1:0]   hdr_sz;
    logic [XW-1:0]       nxt_calc;
    logic                split_r;
    logic [XW-1:0]       rd_a, rd_b;
    logic [XW-1:0]       wr_base, wr_addr;
    logic [15:0]         wr_hv;
    logic [7:0]          wr_data;
    logic                wr_en;
    logic [SIZE_W-1:0]   init_sz;
    logic [7:0]          init_byte;
    logic [XW-1:0]       alloc_addr;

    assign size15   = SIZE_W'(req_reg.request_size);
    assign hdr      = {rd_hi_reg, rd_lo_reg};
    assign hdr_sz   = hdr[SIZE_W-1:0];
    assign nxt_calc = XW'(pos_reg) + XW'(hdr_sz) + XW'(HDR_BYTES);
    assign split_r  = {1'b0, cur_sz_reg} >= ({1'b0, size15} + 16'(HDR_BYTES));
    assign alloc_addr = XW'(pos_reg) + XW'(HDR_BYTES);

    always_comb
    begin
        sts.init_last  = (init_addr_reg == IW'(STORE_BYTES - 1));
        sts.action     = req_reg.action;
        sts.too_big    = size15 > SIZE_W'(MAX_BLOCK_BYTES);
        sts.handle_low = req_reg.handle < FIELD_W'(HDR_BYTES);
        sts.step_over  = steps_reg >= SW'(STEP_LIMIT);
        sts.hdr_busy   = hdr[15];
        sts.hdr_small  = hdr_sz < size15;
        sts.nxt_out    = nxt_calc >= XW'(STORE_BYTES);
        sts.can_split  = {1'b0, hdr_sz} >= ({1'b0, size15} + 16'(HDR_BYTES));
        sts.merge_ok   = !cur_busy_reg && !hdr[15];
        sts.hbyte_busy = rd_lo_reg[7];
    end

    // reset image of the store, one byte per sweep step
    always_comb
    begin
        init_sz = SIZE_W'(PAY);
        if (init_addr_reg >= IW'(LAST_BASE - STRIDE))
            init_sz = SIZE_W'(LAST_PAY);
        init_byte = 8'h00;
        if (init_addr_reg < IW'(LAST_BASE))
        begin
            if (phase_reg == PHW'(0))
                init_byte = init_sz[7:0];
            else if (phase_reg == PHW'(1))
                init_byte = {1'b0, init_sz[SIZE_W-1:8]};
        end
        else if (REM >= HDR_BYTES)
        begin
            if (init_addr_reg == IW'(LAST_BASE))
                init_byte = 8'(TAIL_SZ);
            else if (init_addr_reg == IW'(LAST_BASE + 1))
                init_byte = 8'(TAIL_SZ / 256);
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_POS:  rd_a = XW'(pos_reg);
            RD_NXT:  rd_a = nxt_reg;
            RD_HND:  rd_a = XW'(req_reg.handle) - XW'(1);
            default: rd_a = '0;
        endcase
        rd_b = rd_a + XW'(1);
    end

    always_comb
    begin
        wr_base = '0;
        wr_hv   = '0;
        case (cmd.wr_sel)
            WR_MERGE:
            begin
                wr_base = XW'(pos_reg);
                wr_hv   = {1'b0, cur_sz_reg + SIZE_W'(HDR_BYTES) + hdr_sz};
            end
            WR_SPLIT:
            begin
                wr_base = XW'(pos_reg) + XW'(size15) + XW'(HDR_BYTES);
                wr_hv   = {1'b0, cur_sz_reg - size15 - SIZE_W'(HDR_BYTES)};
            end
            WR_BUSY:
            begin
                wr_base = XW'(pos_reg);
                wr_hv   = {1'b1, split_r ? size15 : cur_sz_reg};
            end
            WR_CLEAR:
            begin
                wr_base = XW'(req_reg.handle) - XW'(1);
                wr_hv   = {8'h00, rd_lo_reg & 8'h7F};
            end
            default:
            begin
                wr_base = '0;
                wr_hv   = '0;
            end
        endcase
        if (cmd.init_step)
        begin
            wr_addr = XW'(init_addr_reg);
            wr_data = init_byte;
        end
        else
        begin
            wr_addr = wr_base + XW'(cmd.wr_hi);
            wr_data = cmd.wr_hi ? wr_hv[15:8] : wr_hv[7:0];
        end
        wr_en = (cmd.init_step || (cmd.wr_sel != WR_NONE)) && (wr_addr < XW'(STORE_BYTES));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[AW-1:0]] <= wr_data;
        if (cmd.rd_sel != RD_NONE)
        begin
            rd_lo_reg <= (rd_a < XW'(STORE_BYTES)) ? mem[rd_a[AW-1:0]] : 8'h00;
            rd_hi_reg <= (rd_b < XW'(STORE_BYTES)) ? mem[rd_b[AW-1:0]] : 8'h00;
        end
    end

    always_comb
    begin
        req_next      = cmd.load ? request : req_reg;
        pos_next      = pos_reg;
        steps_next    = steps_reg;
        cur_busy_next = cur_busy_reg;
        cur_sz_next   = cur_sz_reg;
        nxt_next      = nxt_reg;
        if (cmd.load)
        begin
            pos_next   = '0;
            steps_next = '0;
        end
        if (cmd.eval_hdr)
        begin
            steps_next    = steps_reg + SW'(1);
            cur_busy_next = hdr[15];
            cur_sz_next   = hdr_sz;
            nxt_next      = nxt_calc;
        end
        if (cmd.pos_adv)
            pos_next = nxt_reg[AW-1:0];

        init_addr_next = init_addr_reg;
        phase_next     = phase_reg;
        if (cmd.init_step)
        begin
            init_addr_next = init_addr_reg + IW'(1);
            phase_next = (phase_reg == PHW'(STRIDE - 1)) ? '0 : phase_reg + PHW'(1);
        end

        rsp_next = rsp_reg;
        if (cmd.finish)
        begin
            rsp_next.status = cmd.fin_status;
            case (cmd.fin_addr)
                ADDR_POS: rsp_next.address = alloc_addr[ADDR_W-1:0];
                ADDR_ACC: rsp_next.address = ADDR_W'(req_reg.handle)
                                           + ADDR_W'(req_reg.access_offset);
                default:  rsp_next.address = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_addr_reg <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            init_addr_reg <= init_addr_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pos_reg      <= pos_next;
        steps_reg    <= steps_next;
        cur_busy_reg <= cur_busy_next;
        cur_sz_reg   <= cur_sz_next;
        nxt_reg      <= nxt_next;
        rsp_reg      <= rsp_next;
    end

    assign result = rsp_reg;

endmodule
`default_nettype wire

// ----- hdl/ffba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: store init sweep, request decode, first-fit walk, header writes.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire ffba_pkg::ffba_sts_t  sts,
    output ffba_pkg::ffba_cmd_t       cmd,
    output logic                      busy,
    output logic                      done
);
    import ffba_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_HRD    = 4'd3;
    localparam logic [3:0] S_HEVAL  = 4'd4;
    localparam logic [3:0] S_NRD    = 4'd5;
    localparam logic [3:0] S_NEVAL  = 4'd6;
    localparam logic [3:0] S_WMLO   = 4'd7;
    localparam logic [3:0] S_WMHI   = 4'd8;
    localparam logic [3:0] S_WSLO   = 4'd9;
    localparam logic [3:0] S_WSHI   = 4'd10;
    localparam logic [3:0] S_WBLO   = 4'd11;
    localparam logic [3:0] S_WBHI   = 4'd12;
    localparam logic [3:0] S_BRD    = 4'd13;
    localparam logic [3:0] S_BEVAL  = 4'd14;
    localparam logic [3:0] S_WCLR   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.action == ACT_ALLOC)
                begin
                    if (sts.too_big)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_NOMEM;
                        state_next     = S_IDLE;
                    end
                    else
                        state_next = S_HRD;
                end
                else if ((sts.action inside {ACT_FREE, ACT_ACCESS}) && !sts.handle_low)
                    state_next = S_BRD;
                else
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_INVALID;
                    state_next     = S_IDLE;
                end
            end
            S_HRD:
            begin
                cmd.rd_sel = RD_POS;
                state_next = S_HEVAL;
            end
            S_HEVAL:
            begin
                cmd.eval_hdr = 1'b1;
                if (sts.step_over
                    || ((sts.hdr_busy || sts.hdr_small) && sts.nxt_out))
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NOMEM;
                    state_next     = S_IDLE;
                end
                else if (sts.hdr_busy || sts.hdr_small)
                    state_next = S_NRD;
                else if (sts.can_split)
                    state_next = S_WSLO;
                else
                    state_next = S_WBLO;
            end
            S_NRD:
            begin
                cmd.rd_sel = RD_NXT;
                state_next = S_NEVAL;
            end
            S_NEVAL:
            begin
                if (sts.merge_ok)
                    state_next = S_WMLO;
                else
                begin
                    cmd.pos_adv = 1'b1;
                    state_next  = S_HRD;
                end
            end
            S_WMLO:
            begin
                cmd.wr_sel = WR_MERGE;
                state_next = S_WMHI;
            end
            S_WMHI:
            begin
                cmd.wr_sel = WR_MERGE;
                cmd.wr_hi  = 1'b1;
                state_next = S_HRD;
            end
            S_WSLO:
            begin
                cmd.wr_sel = WR_SPLIT;
                state_next = S_WSHI;
            end
            S_WSHI:
            begin
                cmd.wr_sel = WR_SPLIT;
                cmd.wr_hi  = 1'b1;
                state_next = S_WBLO;
            end
            S_WBLO:
            begin
                cmd.wr_sel = WR_BUSY;
                state_next = S_WBHI;
            end
            S_WBHI:
            begin
                cmd.wr_sel     = WR_BUSY;
                cmd.wr_hi      = 1'b1;
                cmd.finish     = 1'b1;
                cmd.fin_status = ST_OK;
                cmd.fin_addr   = ADDR_POS;
                state_next     = S_IDLE;
            end
            S_BRD:
            begin
                cmd.rd_sel = RD_HND;
                state_next = S_BEVAL;
            end
            S_BEVAL:
            begin
                if (!sts.hbyte_busy)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_INVALID;
                    state_next     = S_IDLE;
                end
                else if (sts.action == ACT_FREE)
                    state_next = S_WCLR;
                else
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_OK;
                    cmd.fin_addr   = ADDR_ACC;
                    state_next     = S_IDLE;
                end
            end
            S_WCLR:
            begin
                cmd.wr_sel     = WR_CLEAR;
                cmd.finish     = 1'b1;
                cmd.fin_status = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        done_next = cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

// ----- hdl/first_fit_block_allocator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit block allocator over a byte store with lazy free-block merging.
// ----------------------------------------------------------------------------
// Usage:
//   A request (allocate, free, access) is taken at a clock edge with start
//   high and busy low. Its result appears on result for one cycle with done
//   high; there is no backpressure on the result side.
//   Free and access read the header below the handle; free then clears
//   its busy bit. Allocate reads each header in turn, steps over blocks,
//   merges free neighbors, and ends with the busy header write, preceded
//   by a split header write when the block splits; a walk that runs out
//   of store ends at the header check. The walk is one header at a time
//   through the single byte-store write port and the paired read port;
//   the worst case visits every header in the store.
//   A new request can be taken in the cycle that done is high.
//   Reset: after rst_n releases, busy stays high while the store is swept
//   and the initial free block headers are written; no request is taken
//   during that sweep.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
    parameter int STORE_BYTES     = 512,
    parameter int MAX_BLOCK_BYTES = 255
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire ffba_pkg::ffba_req_t  request,
    output logic                      busy,
    output logic                      done,
    output ffba_pkg::ffba_rsp_t       result
);
    import ffba_pkg::*;

    ffba_cmd_t cmd;
    ffba_sts_t sts;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ffba_dpath #(
        .STORE_BYTES     (STORE_BYTES),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .sts     (sts),
        .result  (result)
    );

endmodule
`default_nettype wire

// ----- hdl/ffba_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator request/result sequencing.
// ----------------------------------------------------------------------------
module ffba_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire ffba_pkg::ffba_rsp_t  result
);
    import ffba_pkg::*;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a request in flight");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results back to back");

    a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (result.address == '0))
        else $error("error result carries an address");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block allocator core. A shadow heap
// predicts the status and address of every request (allocate, free, access)
// as it is accepted. Each reply is checked against the oldest prediction.
// Directed requests come first, then randomized traffic that mostly frees and
// touches blocks it has allocated.
// ----------------------------------------------------------------------------
module tb_top;
    import ffba_pkg::*;

    localparam int STORE_BYTES     = 512;
    localparam int MAX_BLOCK_BYTES = 255;
    localparam int USED_FLAG       = 'h8000;
    localparam int SIZE_MASK       = 'h7FFF;
    localparam int RANDOM_REQUESTS = 800;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      start;
    ffba_req_t request;
    logic      busy;
    logic      done;
    ffba_rsp_t result;

    logic [7:0] shadow_heap [STORE_BYTES];
    ffba_rsp_t  replies_due [$];
    int         live_handles [$];
    int         fail_count = 0;
    int         burst_left = 0;

    first_fit_block_allocator_core #(
        .STORE_BYTES     (STORE_BYTES),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int heap_byte(int at);
        return (at < STORE_BYTES) ? int'(shadow_heap[at]) : 0;
    endfunction

    function automatic void put_byte(int at, int v);
        if (at < STORE_BYTES)
            shadow_heap[at] = v[7:0];
    endfunction

    function automatic int heap_hdr(int at);
        return heap_byte(at) | (heap_byte(at + 1) << 8);
    endfunction

    function automatic void put_hdr(int at, bit used, int size);
        int h;
        h = (used ? USED_FLAG : 0) | (size & SIZE_MASK);
        put_byte(at, h);
        put_byte(at + 1, h >> 8);
    endfunction

    function automatic void lay_out_heap();
        int pay;
        int stride;
        int count;
        int rem;
        pay    = MAX_BLOCK_BYTES / 2;
        stride = pay + HDR_BYTES;
        count  = STORE_BYTES / stride;
        rem    = STORE_BYTES % stride;
        for (int i = 0; i < STORE_BYTES; i++)
            shadow_heap[i] = 8'h00;
        for (int i = 0; i < count; i++)
            put_hdr(i * stride, 1'b0, pay);
        if (rem >= HDR_BYTES)
            put_hdr(count * stride, 1'b0, rem - HDR_BYTES);
        else if (rem > 0 && count > 0)
            put_hdr((count - 1) * stride, 1'b0, pay + rem);
    endfunction

    // first-fit walk, merging free neighbors on the way
    function automatic ffba_rsp_t place_block(int size);
        ffba_rsp_t rsp;
        int        pos;
        int        steps;
        int        h;
        int        sz;
        int        nxt;
        int        nh;
        bit        used;
        rsp.status  = ST_NOMEM;
        rsp.address = '0;
        pos   = 0;
        steps = 0;
        if (size > MAX_BLOCK_BYTES)
            return rsp;
        while (1)
        begin
            h    = heap_hdr(pos);
            used = (h & USED_FLAG) != 0;
            sz   = h & SIZE_MASK;
            steps++;
            if (steps > 2 * STORE_BYTES + 4)
                return rsp;
            if (used || sz < size)
            begin
                nxt = pos + sz + HDR_BYTES;
                if (nxt >= STORE_BYTES)
                    return rsp;
                nh = heap_hdr(nxt);
                if (!used && (nh & USED_FLAG) == 0)
                    put_hdr(pos, 1'b0, sz + HDR_BYTES + (nh & SIZE_MASK));
                else
                    pos = nxt;
            end
            else
            begin
                if (sz >= size + HDR_BYTES)
                begin
                    put_hdr(pos + size + HDR_BYTES, 1'b0, sz - size - HDR_BYTES);
                    sz = size;
                end
                put_hdr(pos, 1'b1, sz);
                rsp.status  = ST_OK;
                rsp.address = ADDR_W'(pos + HDR_BYTES);
                return rsp;
            end
        end
        return rsp;
    endfunction

    function automatic ffba_rsp_t predict_reply(ffba_req_t req);
        ffba_rsp_t rsp;
        int        hnd;
        bit        marked;
        rsp.status  = ST_INVALID;
        rsp.address = '0;
        hnd    = int'(req.handle);
        marked = (hnd >= HDR_BYTES) && ((heap_byte(hnd - 1) & 'h80) != 0);
        case (req.action)
            ACT_ALLOC:
                rsp = place_block(int'(req.request_size));
            ACT_FREE:
                if (marked)
                begin
                    put_byte(hnd - 1, heap_byte(hnd - 1) & 'h7F);
                    rsp.status = ST_OK;
                end
            ACT_ACCESS:
                if (marked)
                begin
                    rsp.status  = ST_OK;
                    rsp.address = ADDR_W'(hnd + int'(req.access_offset));
                end
            default:
                ;
        endcase
        return rsp;
    endfunction

    function automatic ffba_req_t make_req(logic [ACTION_W-1:0] act, int size, int hnd,
                                           int offs);
        ffba_req_t req;
        req.action        = act;
        req.request_size  = FIELD_W'(size);
        req.handle        = FIELD_W'(hnd);
        req.access_offset = FIELD_W'(offs);
        return req;
    endfunction

    task automatic send_request(input ffba_req_t req);
        ffba_rsp_t rsp;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 30)
                                                  : $urandom_range(12, 1);
            gap = $urandom_range(8, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        rsp = predict_reply(req);
        replies_due.push_back(rsp);
        if (req.action == ACT_ALLOC && rsp.status == ST_OK)
            live_handles.push_back(int'(rsp.address));
        if (req.action == ACT_FREE && rsp.status == ST_OK)
        begin
            for (int k = 0; k < live_handles.size(); k++)
            begin
                if (live_handles[k] == int'(req.handle))
                begin
                    live_handles.delete(k);
                    break;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : check_reply
        ffba_rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply with none pending: expected none, actual status=%0d address=%0d",
                         $time, result.status, result.address);
                fail_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (result.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, result.status);
                    fail_count++;
                end
                if (result.address !== want.address)
                begin
                    $display("%0t: address mismatch: expected %0d, actual %0d",
                             $time, want.address, result.address);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_oversize();
        send_request(make_req(ACT_ALLOC, MAX_BLOCK_BYTES + 1, 511, 0));
        send_request(make_req(ACT_ALLOC, 511, 0, 511));
    endtask

    task automatic test_first_fit();
        send_request(make_req(ACT_ALLOC, 0, 0, 0));
        send_request(make_req(ACT_ALLOC, MAX_BLOCK_BYTES, 511, 511));
        send_request(make_req(ACT_ALLOC, 125, 256, 1));
        send_request(make_req(ACT_ALLOC, MAX_BLOCK_BYTES, 170, 340));
        send_request(make_req(ACT_ALLOC, 1, 85, 426));
    endtask

    task automatic test_handles();
        int hnd;
        if (live_handles.size() > 0)
        begin
            hnd = live_handles[0];
            send_request(make_req(ACT_ACCESS, 0, hnd, 0));
            send_request(make_req(ACT_ACCESS, 511, hnd, 511));
            send_request(make_req(ACT_FREE, 0, hnd, 0));
            send_request(make_req(ACT_FREE, 0, hnd, 0));
            send_request(make_req(ACT_ACCESS, 0, hnd, 7));
        end
        send_request(make_req(ACT_FREE, 511, 0, 511));
        send_request(make_req(ACT_FREE, 0, 1, 0));
        send_request(make_req(ACT_ACCESS, 0, 1, 511));
        send_request(make_req(ACT_ACCESS, 0, 511, 511));
    endtask

    task automatic test_unknown_action();
        send_request(make_req(ACT_UNUSED, 511, 511, 511));
    endtask

    task automatic test_release_all();
        while (live_handles.size() > 0)
            send_request(make_req(ACT_FREE, 0, live_handles[0], 0));
        send_request(make_req(ACT_ALLOC, MAX_BLOCK_BYTES, 0, 0));
    endtask

    task automatic test_random(input int count);
        ffba_req_t req;
        int        r;
        int        sz;
        for (int n = 0; n < count; n++)
        begin
            req = ffba_req_t'($urandom);
            r   = $urandom_range(99);
            if (live_handles.size() > 20)
                r = 50;
            if (live_handles.size() == 0 && r >= 40 && r < 85)
                r = 0;
            if (r < 40)
            begin
                sz = $urandom_range(99);
                if (sz < 70)
                    sz = $urandom_range(24);
                else if (sz < 90)
                    sz = $urandom_range(130, 25);
                else if (sz < 97)
                    sz = $urandom_range(MAX_BLOCK_BYTES, 131);
                else
                    sz = $urandom_range(511, MAX_BLOCK_BYTES + 1);
                req.action       = ACT_ALLOC;
                req.request_size = FIELD_W'(sz);
            end
            else if (r < 65)
            begin
                req.action = ACT_FREE;
                req.handle = FIELD_W'(live_handles[$urandom_range(live_handles.size() - 1)]);
            end
            else if (r < 85)
            begin
                req.action = ACT_ACCESS;
                req.handle = FIELD_W'(live_handles[$urandom_range(live_handles.size() - 1)]);
            end
            else if (r < 90)
                req.action = ACT_FREE;
            else if (r < 95)
                req.action = ACT_ACCESS;
            else if (r < 98)
                req.action = ACT_UNUSED;
            else
            begin
                req.action = ($urandom_range(1) == 0) ? ACT_FREE : ACT_ACCESS;
                req.handle = FIELD_W'($urandom_range(3));
            end
            send_request(req);
        end
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        while (replies_due.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        start   <= 1'b0;
        request <= '0;
        rst_n   <= 1'b0;
        lay_out_heap();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_oversize();
        test_first_fit();
        test_handles();
        test_unknown_action();
        test_release_all();
        test_random(RANDOM_REQUESTS);
        drain_replies();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
